[rtl/core/barc_pkg.sv]
// Package for the button auto-repeat counter: types, codes and reset values.
`default_nettype none
package barc_pkg;

    localparam int TickWidth  = 16;
    localparam int CountWidth = 8;
    localparam int BtnWidth   = 2;
    localparam int CfgIdxWidth  = 2;
    localparam int CfgDataWidth = 16;

    // Register indexes on the configuration port.
    localparam logic [CfgIdxWidth-1:0] CFG_SLOW_PERIOD = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_FAST_AFTER  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_FAST_PERIOD = 2'd2;
    localparam logic [CfgIdxWidth-1:0] CFG_TOP_VALUE   = 2'd3;

    // Reset values of the registers.
    localparam logic [TickWidth-1:0]  SLOW_PERIOD_RST = 16'd1000;
    localparam logic [TickWidth-1:0]  FAST_AFTER_RST  = 16'd3000;
    localparam logic [TickWidth-1:0]  FAST_PERIOD_RST = 16'd400;
    localparam logic [CountWidth-1:0] TOP_VALUE_RST   = 8'd9;

    // Button codes.
    localparam logic [BtnWidth-1:0] BTN_NONE = 2'b00;
    localparam logic [BtnWidth-1:0] BTN_UP   = 2'b01;
    localparam logic [BtnWidth-1:0] BTN_DOWN = 2'b10;
    localparam logic [BtnWidth-1:0] BTN_BOTH = 2'b11;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_UP      = 3'd1,
        MODE_UP_HOLD = 3'd2,
        MODE_DN      = 3'd3,
        MODE_DN_HOLD = 3'd4,
        MODE_CLR     = 3'd5
    } t_mode;

    typedef struct packed {
        t_mode                 mode;
        logic [TickWidth-1:0]  repeat_ticks;
        logic [TickWidth-1:0]  hold_total;
        logic [TickWidth-1:0]  fast_ticks;
        logic [CountWidth-1:0] count;
    } t_state;

    typedef struct packed {
        logic [TickWidth-1:0]  slow_period;
        logic [TickWidth-1:0]  fast_after;
        logic [TickWidth-1:0]  fast_period;
        logic [CountWidth-1:0] top_value;
    } t_cfg;

endpackage
`default_nettype wire

[rtl/core/barc_step.sv]
// Next-state logic for one tick: mode transition, hold timing, count update.
`default_nettype none
module barc_step
    import barc_pkg::*;
(
    input  wire t_state              i_state,
    input  wire t_cfg                i_cfg,
    input  wire logic [BtnWidth-1:0] i_buttons,
    output t_state                   o_state
);

    logic lt_slow;
    logic lt_fast;
    logic lt_fast_period;
    logic valid_mode;
    t_state nxt;

    assign lt_slow        = i_state.repeat_ticks < i_cfg.slow_period;
    assign lt_fast        = i_state.hold_total < i_cfg.fast_after;
    assign lt_fast_period = i_state.fast_ticks < i_cfg.fast_period;

    always_comb begin
        nxt        = i_state;
        valid_mode = 1'b1;

        // Mode transition.
        unique case (i_state.mode)
            MODE_IDLE, MODE_UP, MODE_UP_HOLD, MODE_DN, MODE_DN_HOLD, MODE_CLR: begin
                valid_mode = 1'b1;
            end
            default: begin
                valid_mode = 1'b0;
            end
        endcase

        if (!valid_mode) begin
            // Undefined code: back to idle, count untouched.
            nxt.mode = MODE_IDLE;
        end else begin
            case (i_buttons)
                BTN_BOTH: nxt.mode = MODE_CLR;
                BTN_UP, BTN_DOWN: begin
                    if ((i_buttons == BTN_UP && i_state.mode == MODE_UP) ||
                        (i_buttons == BTN_DOWN && i_state.mode == MODE_DN)) begin
                        nxt.repeat_ticks = '0;
                        nxt.fast_ticks   = '0;
                        nxt.mode = (i_buttons == BTN_UP) ? MODE_UP_HOLD : MODE_DN_HOLD;
                    end else if ((i_buttons == BTN_UP && i_state.mode == MODE_UP_HOLD) ||
                                 (i_buttons == BTN_DOWN && i_state.mode == MODE_DN_HOLD)) begin
                        // Hold timing: slow phase, then fast phase.
                        if (lt_slow && lt_fast) begin
                            nxt.repeat_ticks = i_state.repeat_ticks + 16'd1;
                            nxt.hold_total   = i_state.hold_total + 16'd1;
                        end else if (lt_fast) begin
                            nxt.hold_total = i_state.hold_total + 16'd1;
                            nxt.mode = (i_buttons == BTN_UP) ? MODE_UP : MODE_DN;
                        end else if (lt_fast_period) begin
                            nxt.fast_ticks = i_state.fast_ticks + 16'd1;
                        end else begin
                            nxt.mode = (i_buttons == BTN_UP) ? MODE_UP : MODE_DN;
                        end
                    end else begin
                        // Fresh press.
                        nxt.hold_total = '0;
                        nxt.mode = (i_buttons == BTN_UP) ? MODE_UP : MODE_DN;
                    end
                end
                default: begin
                    if (i_state.mode == MODE_CLR) begin
                        nxt.hold_total = '0;
                    end
                    nxt.mode = MODE_IDLE;
                end
            endcase

            // Action of the new mode.
            case (nxt.mode)
                MODE_UP: begin
                    if (i_state.count < i_cfg.top_value) begin
                        nxt.count = i_state.count + 8'd1;
                    end
                end
                MODE_DN: begin
                    if (i_state.count != '0) begin
                        nxt.count = i_state.count - 8'd1;
                    end
                end
                MODE_CLR: nxt.count = '0;
                default:  nxt.count = i_state.count;
            endcase
        end
    end

    assign o_state = nxt;

endmodule
`default_nettype wire

[rtl/core/button_auto_repeat_counter_core.sv]
// Top level of the button auto-repeat up/down counter.
//
// One transaction on the input channel is one timer tick carrying the two
// button bits (bit0 up, bit1 down, both = clear). Each tick produces exactly
// one output transaction with the saturating count after that tick. A fresh
// press steps the count once; while held, it repeats after slow_period ticks
// counted in hold state until fast_after hold ticks have passed, then after
// fast_period counted ticks. A new tick is taken every cycle while o_in_stall
// is low: the whole tick update is one level of logic between the state
// registers. Results go to the output register, or to the skid register on a
// stall; this two-entry buffer takes one more tick after the output stalls,
// and o_in_stall rises only when both entries hold results. Configuration
// writes (index 0 slow_period, 1 fast_after, 2 fast_period, 3 top_value) take
// effect at the next clock edge and must be done while the block is idle.
`default_nettype none
module button_auto_repeat_counter_core
    import barc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // configuration write port
    input  wire logic                    i_cfg_wen,
    input  wire logic [CfgIdxWidth-1:0]  i_cfg_idx,
    input  wire logic [CfgDataWidth-1:0] i_cfg_data,
    // input channel
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [BtnWidth-1:0]     i_buttons,
    // output channel
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [CountWidth-1:0]        o_count_value
);

    t_cfg   r_cfg;
    t_state r_state;
    t_state n_state;

    logic                  r_out_valid;
    logic [CountWidth-1:0] r_out_count;
    logic                  r_skid_valid;
    logic [CountWidth-1:0] r_skid_count;

    logic in_xact;
    logic out_xact;

    assign o_in_stall  = r_skid_valid;
    assign in_xact     = i_in_valid & ~r_skid_valid;
    assign out_xact    = r_out_valid & ~i_out_stall;

    barc_step u_step (
        .i_state   (r_state),
        .i_cfg     (r_cfg),
        .i_buttons (i_buttons),
        .o_state   (n_state)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slow_period <= SLOW_PERIOD_RST;
            r_cfg.fast_after  <= FAST_AFTER_RST;
            r_cfg.fast_period <= FAST_PERIOD_RST;
            r_cfg.top_value   <= TOP_VALUE_RST;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                CFG_SLOW_PERIOD: r_cfg.slow_period <= i_cfg_data;
                CFG_FAST_AFTER:  r_cfg.fast_after  <= i_cfg_data;
                CFG_FAST_PERIOD: r_cfg.fast_period <= i_cfg_data;
                CFG_TOP_VALUE:   r_cfg.top_value   <= i_cfg_data[CountWidth-1:0];
                default:         r_cfg.top_value   <= r_cfg.top_value;
            endcase
        end
    end

    // Tick state: updated once per accepted input transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode         <= MODE_IDLE;
            r_state.repeat_ticks <= '0;
            r_state.hold_total   <= '0;
            r_state.fast_ticks   <= '0;
            r_state.count        <= '0;
        end else if (in_xact) begin
            r_state <= n_state;
        end
    end

    // Output register plus skid entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // input is stalled; drain skid into the output register
            if (out_xact) begin
                r_skid_valid <= 1'b0;
            end
        end else if (in_xact) begin
            if (r_out_valid && !out_xact) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (out_xact) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_xact) begin
                r_out_count <= r_skid_count;
            end
        end else if (in_xact) begin
            if (r_out_valid && !out_xact) begin
                r_skid_count <= n_state.count;
            end else begin
                r_out_count <= n_state.count;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count_value = r_out_count;

endmodule
`default_nettype wire
